[sv/isv_pkg.sv]
package isv_pkg;

  // Prefix matcher states
  typedef enum logic [2:0] {
    PM_START = 3'd0,
    PM_I     = 3'd1,
    PM_IS    = 3'd2,
    PM_ISB   = 3'd3,
    PM_AFTER = 3'd4,
    PM_BODY  = 3'd5
  } pm_t;

  typedef enum logic [3:0] {
    ERR_OK       = 4'd0,
    ERR_BAD_CHAR = 4'd1,
    ERR_GROUPS   = 4'd2,
    ERR_LENGTH   = 4'd3,
    ERR_GRP_LEN  = 4'd4,
    ERR_CHECK_GR = 4'd5,
    ERR_PREFIX   = 4'd6,
    ERR_X_PLACE  = 4'd7,
    ERR_CHECKSUM = 4'd8
  } err_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ISBN10 = 2'd1,
    KIND_ISBN13 = 2'd2
  } kind_t;

  // Error flag bit positions
  localparam int unsigned EF_BAD   = 0;
  localparam int unsigned EF_SIXTH = 1;
  localparam int unsigned EF_LASTX = 2;
  localparam int unsigned EF_EARLX = 3;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HYPH  = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_I  = 8'h49;
  localparam logic [7:0] CH_UP_N  = 8'h4E;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // ISBN-13 prefixes
  localparam logic [9:0] PFX_978 = 10'd978;
  localparam logic [9:0] PFX_979 = 10'd979;

  // Verdict of one text
  typedef struct packed {
    logic  valid_res;
    kind_t kind;
    err_t  error_code;
  } res_t;

endpackage

[sv/isv_engine.sv]
module isv_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       ch,
  input  logic             last,
  output isv_pkg::res_t    res
);

  isv_pkg::pm_t pm_r, pm_nxt;
  logic [3:0] scnt_r, scnt_nxt;
  logic [2:0] gcnt_r, gcnt_nxt;
  logic [3:0] glen_r, glen_nxt;
  logic       gopen_r, gopen_nxt;
  logic [9:0] fgv_r, fgv_nxt;
  logic [3:0] fgl_r, fgl_nxt;
  logic [3:0] ds_r, ds_nxt;
  logic [3:0] ws_r, ws_nxt;
  logic [3:0] wm_r, wm_nxt;
  logic [3:0] ef_r, ef_nxt;

  logic       body_en;
  logic       pfx_bad;
  logic [7:0] up;
  logic       blank;
  logic       crlf;

  assign up    = (ch >= isv_pkg::CH_LO_A && ch <= isv_pkg::CH_LO_Z) ?
                 ch - isv_pkg::CASE_OFS : ch;
  assign blank = (ch == isv_pkg::CH_SPACE) || (ch == isv_pkg::CH_TAB);
  assign crlf  = (ch == isv_pkg::CH_CR) || (ch == isv_pkg::CH_LF);

  // Prefix matcher: next state
  always_comb begin
    pm_nxt = pm_r;
    if (step && !crlf) begin
      case (pm_r)
        isv_pkg::PM_START: begin
          if (!blank) pm_nxt = (up == isv_pkg::CH_UP_I) ? isv_pkg::PM_I : isv_pkg::PM_BODY;
        end
        isv_pkg::PM_I:   pm_nxt = (up == isv_pkg::CH_UP_S) ? isv_pkg::PM_IS : isv_pkg::PM_BODY;
        isv_pkg::PM_IS:  pm_nxt = (up == isv_pkg::CH_UP_B) ? isv_pkg::PM_ISB : isv_pkg::PM_BODY;
        isv_pkg::PM_ISB: pm_nxt = (up == isv_pkg::CH_UP_N) ? isv_pkg::PM_AFTER : isv_pkg::PM_BODY;
        isv_pkg::PM_AFTER: begin
          if (!(ch == isv_pkg::CH_COLON || blank)) pm_nxt = isv_pkg::PM_BODY;
        end
        default: pm_nxt = isv_pkg::PM_BODY;
      endcase
    end
  end

  // Prefix matcher: outputs
  always_comb begin
    body_en = 1'b0;
    pfx_bad = 1'b0;
    if (step && !crlf) begin
      case (pm_r)
        isv_pkg::PM_START: body_en = !blank && (up != isv_pkg::CH_UP_I);
        isv_pkg::PM_I:     pfx_bad = (up != isv_pkg::CH_UP_S);
        isv_pkg::PM_IS:    pfx_bad = (up != isv_pkg::CH_UP_B);
        isv_pkg::PM_ISB:   pfx_bad = (up != isv_pkg::CH_UP_N);
        isv_pkg::PM_AFTER: body_en = !(ch == isv_pkg::CH_COLON || blank);
        default:           body_en = 1'b1;
      endcase
    end
  end

  // Counters, sums and flags
  logic       is_x, is_dig;
  logic [3:0] v;
  logic [4:0] t11;
  logic [5:0] t10;
  logic [5:0] term;
  logic [3:0] scnt_f, glen_f, fgl_f, ef_f;
  logic [2:0] gcnt_f;
  logic       gopen_f;
  logic [9:0] fgv_f;

  always_comb begin
    is_x   = (ch == isv_pkg::CH_UP_X) || (ch == isv_pkg::CH_LO_X);
    is_dig = (ch >= isv_pkg::CH_0) && (ch <= isv_pkg::CH_9);
    v      = is_x ? 4'd10 : ch[3:0];
    t11    = '0;
    t10    = '0;
    term   = '0;

    scnt_nxt  = scnt_r;
    gcnt_nxt  = gcnt_r;
    glen_nxt  = glen_r;
    gopen_nxt = gopen_r;
    fgv_nxt   = fgv_r;
    fgl_nxt   = fgl_r;
    ds_nxt    = ds_r;
    ws_nxt    = ws_r;
    wm_nxt    = wm_r;
    ef_nxt    = ef_r;

    if (pfx_bad && ef_nxt[1:0] == 2'b00) ef_nxt[isv_pkg::EF_BAD] = 1'b1;

    if (body_en) begin
      if (ch == isv_pkg::CH_HYPH || blank) begin
        if (gopen_nxt) begin
          gopen_nxt = 1'b0;
          if (gcnt_nxt >= 3'd5) begin
            if (ef_nxt[1:0] == 2'b00) ef_nxt[isv_pkg::EF_SIXTH] = 1'b1;
          end else begin
            gcnt_nxt = gcnt_nxt + 3'd1;
          end
        end
      end else if (is_dig || is_x) begin
        if (!gopen_nxt) begin
          gopen_nxt = 1'b1;
          glen_nxt  = '0;
        end
        if (glen_nxt != 4'd15) glen_nxt = glen_nxt + 4'd1;
        if (gcnt_nxt == 3'd0) begin
          if (is_x) begin
            fgl_nxt = 4'd15;
          end else if (fgl_nxt < 4'd3) begin
            fgv_nxt = 10'((fgv_nxt << 3) + (fgv_nxt << 1) + 10'(v));
            fgl_nxt = fgl_nxt + 4'd1;
          end else if (fgl_nxt != 4'd15) begin
            fgl_nxt = fgl_nxt + 4'd1;
          end
        end
        if (ef_nxt[isv_pkg::EF_LASTX]) ef_nxt[isv_pkg::EF_EARLX] = 1'b1;
        ef_nxt[isv_pkg::EF_LASTX] = is_x;

        t11 = 5'(ds_r) + 5'(v);
        if (t11 >= 5'd11) t11 = t11 - 5'd11;
        ds_nxt = t11[3:0];
        t11 = 5'(ws_r) + 5'(ds_nxt);
        if (t11 >= 5'd11) t11 = t11 - 5'd11;
        ws_nxt = t11[3:0];

        term = scnt_r[0] ? (6'(v) + 6'({v, 1'b0})) : 6'(v);
        t10  = 6'(wm_r) + term;
        if (t10 >= 6'd30)      t10 = t10 - 6'd30;
        else if (t10 >= 6'd20) t10 = t10 - 6'd20;
        else if (t10 >= 6'd10) t10 = t10 - 6'd10;
        wm_nxt = t10[3:0];

        if (scnt_nxt != 4'd15) scnt_nxt = scnt_nxt + 4'd1;
      end else begin
        if (ef_nxt[1:0] == 2'b00) ef_nxt[isv_pkg::EF_BAD] = 1'b1;
      end
    end

    // End of text: flag a broken prefix and close the open group
    scnt_f  = scnt_nxt;
    glen_f  = glen_nxt;
    fgl_f   = fgl_nxt;
    fgv_f   = fgv_nxt;
    gcnt_f  = gcnt_nxt;
    gopen_f = gopen_nxt;
    ef_f    = ef_nxt;
    if (pm_nxt == isv_pkg::PM_I || pm_nxt == isv_pkg::PM_IS || pm_nxt == isv_pkg::PM_ISB) begin
      if (ef_f[1:0] == 2'b00) ef_f[isv_pkg::EF_BAD] = 1'b1;
    end
    if (gopen_f) begin
      gopen_f = 1'b0;
      if (gcnt_f >= 3'd5) begin
        if (ef_f[1:0] == 2'b00) ef_f[isv_pkg::EF_SIXTH] = 1'b1;
      end else begin
        gcnt_f = gcnt_f + 3'd1;
      end
    end
  end

  // Verdict from the closed-out state
  always_comb begin
    res.kind       = isv_pkg::KIND_NONE;
    res.error_code = isv_pkg::ERR_LENGTH;
    if (ef_f[isv_pkg::EF_BAD]) begin
      res.error_code = isv_pkg::ERR_BAD_CHAR;
    end else if (ef_f[isv_pkg::EF_SIXTH] || gcnt_f < 3'd4 || gcnt_f > 3'd5) begin
      res.error_code = isv_pkg::ERR_GROUPS;
    end else if (scnt_f == 4'd10) begin
      if (gcnt_f != 3'd4)               res.error_code = isv_pkg::ERR_GRP_LEN;
      else if (glen_f != 4'd1)          res.error_code = isv_pkg::ERR_CHECK_GR;
      else if (ef_f[isv_pkg::EF_EARLX]) res.error_code = isv_pkg::ERR_X_PLACE;
      else if (ws_nxt != 4'd0)          res.error_code = isv_pkg::ERR_CHECKSUM;
      else begin
        res.error_code = isv_pkg::ERR_OK;
        res.kind       = isv_pkg::KIND_ISBN10;
      end
    end else if (scnt_f == 4'd13) begin
      if (gcnt_f != 3'd5) res.error_code = isv_pkg::ERR_GRP_LEN;
      else if (fgl_f != 4'd3 || (fgv_f != isv_pkg::PFX_978 && fgv_f != isv_pkg::PFX_979))
        res.error_code = isv_pkg::ERR_PREFIX;
      else if (glen_f != 4'd1) res.error_code = isv_pkg::ERR_CHECK_GR;
      else if (ef_f[isv_pkg::EF_LASTX] || ef_f[isv_pkg::EF_EARLX])
        res.error_code = isv_pkg::ERR_X_PLACE;
      else if (wm_nxt != 4'd0) res.error_code = isv_pkg::ERR_CHECKSUM;
      else begin
        res.error_code = isv_pkg::ERR_OK;
        res.kind       = isv_pkg::KIND_ISBN13;
      end
    end
    res.valid_res = (res.error_code == isv_pkg::ERR_OK);
  end

  // Hold state between bytes; clear it after every verdict
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      pm_r    <= isv_pkg::PM_START;
      scnt_r  <= '0;
      gcnt_r  <= '0;
      glen_r  <= '0;
      gopen_r <= 1'b0;
      fgv_r   <= '0;
      fgl_r   <= '0;
      ds_r    <= '0;
      ws_r    <= '0;
      wm_r    <= '0;
      ef_r    <= '0;
    end else if (step) begin
      pm_r    <= pm_nxt;
      scnt_r  <= scnt_nxt;
      gcnt_r  <= gcnt_nxt;
      glen_r  <= glen_nxt;
      gopen_r <= gopen_nxt;
      fgv_r   <= fgv_nxt;
      fgl_r   <= fgl_nxt;
      ds_r    <= ds_nxt;
      ws_r    <= ws_nxt;
      wm_r    <= wm_nxt;
      ef_r    <= ef_nxt;
    end
  end

endmodule

[sv/isbn_stream_validator_top.sv]
// ISBN text checker. Feed the text one byte per request on the in_ channel and
// mark its final byte with in_tlast; one verdict request per text follows on
// the out_ channel (valid flag, kind ISBN-10/ISBN-13, error code). CR and LF
// are ignored, leading blanks and an optional "ISBN" prefix (any case, with
// trailing colons and blanks) are stripped, hyphens and blanks separate
// groups. The block takes one byte every clock cycle unless a held last byte
// waits for out_tready: each byte sits in the input register, the running
// counters and checksums advance in a single step from it, and the verdict is
// loaded into the output register as the last byte leaves. Input and output
// registers let a new byte be taken while a verdict still waits for out_tready.
module isbn_stream_validator_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic       in_tlast,   // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] valid_res, [2:1] kind, [6:3] error_code, [7] zero
);

  logic          hold_v_r;
  logic [7:0]    hold_ch_r;
  logic          hold_last_r;
  logic          go;
  logic          out_valid_r;
  isv_pkg::res_t out_res_r;
  isv_pkg::res_t res;

  // Advance the held byte unless it carries a verdict that has nowhere to go
  assign go        = hold_v_r && (!hold_last_r || !out_valid_r || out_tready);
  assign in_tready = !hold_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_tready) begin
      hold_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      hold_ch_r   <= in_tdata;
      hold_last_r <= in_tlast;
    end
  end

  isv_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (go),
    .ch    (hold_ch_r),
    .last  (hold_last_r),
    .res   (res)
  );

  // Load the verdict on the last byte; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && hold_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && hold_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.error_code, out_res_r.kind, out_res_r.valid_res};

endmodule
